// ----- hw/rtl/http_request_url_matcher_core_assert.svh -----
// Assertion macros shared by the URL matcher RTL.
// Each macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef HTTP_REQUEST_URL_MATCHER_CORE_ASSERT_SVH
`define HTTP_REQUEST_URL_MATCHER_CORE_ASSERT_SVH

// Concurrent property checked on every clock edge outside reset.
`define HRUM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that must never be seen outside reset.
`define HRUM_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- hw/rtl/hrum_pkg.sv -----
// Package for the URL matcher: payload structs, status codes and default sizes.
// No dependencies; every RTL module uses it by scoped names.
package hrum_pkg;

    localparam int NUM_ENTRIES_DEF = 16;
    localparam int PATH_MAX_DEF    = 128;
    localparam int METHOD_MAX_DEF  = 8;

    localparam int STATUS_W = 3;
    localparam int INDEX_W  = 4;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd2;
    localparam logic [STATUS_W-1:0] ST_REG      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

    localparam logic TYPE_REGISTER = 1'b0;
    localparam logic TYPE_REQUEST  = 1'b1;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_CR    = 8'h0D;

    typedef struct packed {
        logic       req_type;
        logic [7:0] data_byte;
        logic       last_byte;
    } item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [INDEX_W-1:0]  entry_index;
    } result_t;

    // Search token that walks the cell chain at the end of a request.
    typedef struct packed {
        logic    valid;
        logic    done;
        result_t res;
    } tok_t;

    // Events the front end reports for the accepted transaction.
    typedef struct packed {
        logic    reg_valid;
        result_t reg_res;
        logic    fin;
        logic    bad;
    } evt_t;

endpackage

// ----- hw/rtl/hrum_front.sv -----
// Front end of the URL matcher: request-line parser and registration writer.
// Depends on hrum_pkg; drives the write and compare commands of the cell chain.
module hrum_front #(
    parameter int NUM_ENTRIES = hrum_pkg::NUM_ENTRIES_DEF,
    parameter int PATH_MAX    = hrum_pkg::PATH_MAX_DEF,
    parameter int METHOD_MAX  = hrum_pkg::METHOD_MAX_DEF,
    localparam int AW  = $clog2(PATH_MAX),
    localparam int MW  = $clog2(METHOD_MAX),
    localparam int PW  = (MW > AW) ? MW : AW,
    localparam int UW  = $clog2(NUM_ENTRIES + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  hrum_pkg::item_t     item,
    output logic                wr_en,
    output logic [UW-1:0]       used,
    output logic [AW-1:0]       wr_addr,
    output logic [7:0]          wr_data,
    output logic                len_we,
    output logic [AW-1:0]       len_val,
    output logic                cmp_en,
    output logic [AW-1:0]       cmp_addr,
    output logic [AW-1:0]       final_len,
    output hrum_pkg::evt_t      evt
);

    localparam int IW = hrum_pkg::INDEX_W;

    localparam logic [1:0] PH_METHOD = 2'd0;
    localparam logic [1:0] PH_PATH   = 2'd1;
    localparam logic [1:0] PH_SKIP   = 2'd2;

    logic [1:0]    phase_reg, phase_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic          err_reg, err_next;
    logic [AW-1:0] rpos_reg, rpos_next;
    logic          rend_reg, rend_next;
    logic [UW-1:0] used_reg, used_next;

    assign used     = used_reg;
    assign wr_addr  = rpos_reg;
    assign wr_data  = item.data_byte;
    assign cmp_addr = pos_reg[AW-1:0];

    always_comb
    begin
        logic [7:0]    b;
        logic [AW-1:0] rp;
        logic [1:0]    ph;
        logic [PW-1:0] p;
        logic          e;
        b          = item.data_byte;
        rp         = rpos_reg;
        ph         = phase_reg;
        p          = pos_reg;
        e          = err_reg;
        phase_next = phase_reg;
        pos_next   = pos_reg;
        err_next   = err_reg;
        rpos_next  = rpos_reg;
        rend_next  = rend_reg;
        used_next  = used_reg;
        wr_en      = 1'b0;
        len_we     = 1'b0;
        len_val    = '0;
        cmp_en     = 1'b0;
        final_len  = '0;
        evt        = '0;
        if (accept)
        begin
            if (item.req_type == hrum_pkg::TYPE_REGISTER)
            begin
                if (!rend_reg)
                begin
                    if (b == hrum_pkg::CHAR_NUL)
                    begin
                        rend_next = 1'b1;
                    end
                    else if (used_reg < UW'(NUM_ENTRIES) && rpos_reg < AW'(PATH_MAX - 1))
                    begin
                        wr_en = 1'b1;
                        rp    = rpos_reg + AW'(1);
                    end
                end
                rpos_next = rp;
                len_val   = rp;
                if (item.last_byte)
                begin
                    evt.reg_valid = 1'b1;
                    if (used_reg >= UW'(NUM_ENTRIES))
                    begin
                        evt.reg_res.status      = hrum_pkg::ST_FULL;
                        evt.reg_res.entry_index = '0;
                    end
                    else
                    begin
                        evt.reg_res.status      = hrum_pkg::ST_REG;
                        evt.reg_res.entry_index = IW'(used_reg);
                        if (rp != '0)
                        begin
                            len_we    = 1'b1;
                            used_next = used_reg + UW'(1);
                        end
                    end
                    rpos_next = '0;
                    rend_next = 1'b0;
                end
            end
            else
            begin
                if (!(e || ph == PH_SKIP))
                begin
                    if (ph == PH_METHOD)
                    begin
                        if (b == hrum_pkg::CHAR_SPACE)
                        begin
                            if (p == '0)
                            begin
                                e = 1'b1;
                            end
                            ph = PH_PATH;
                            p  = '0;
                        end
                        else if (p >= PW'(METHOD_MAX - 1))
                        begin
                            e = 1'b1;
                        end
                        else
                        begin
                            if (p == '0 && b == hrum_pkg::CHAR_NUL)
                            begin
                                e = 1'b1;
                            end
                            p = p + PW'(1);
                        end
                    end
                    else if (b == hrum_pkg::CHAR_SPACE || b == hrum_pkg::CHAR_CR ||
                             b == hrum_pkg::CHAR_NUL || p >= PW'(PATH_MAX - 1))
                    begin
                        ph = PH_SKIP;
                    end
                    else
                    begin
                        cmp_en = 1'b1;
                        p      = p + PW'(1);
                    end
                end
                if (item.last_byte)
                begin
                    evt.fin    = 1'b1;
                    evt.bad    = e || ph == PH_METHOD || p == '0;
                    final_len  = p[AW-1:0];
                    phase_next = PH_METHOD;
                    pos_next   = '0;
                    err_next   = 1'b0;
                end
                else
                begin
                    phase_next = ph;
                    pos_next   = p;
                    err_next   = e;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_METHOD;
            pos_reg   <= '0;
            err_reg   <= 1'b0;
            rpos_reg  <= '0;
            rend_reg  <= 1'b0;
            used_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            err_reg   <= err_next;
            rpos_reg  <= rpos_next;
            rend_reg  <= rend_next;
            used_reg  <= used_next;
        end
    end

endmodule

// ----- hw/rtl/hrum_cell.sv -----
// One table slot of the URL matcher: path bytes, length, match flag, search stage.
// Depends on hrum_pkg; chained by the top level, one cell per slot.
module hrum_cell #(
    parameter int SLOT        = 0,
    parameter int NUM_ENTRIES = hrum_pkg::NUM_ENTRIES_DEF,
    parameter int PATH_MAX    = hrum_pkg::PATH_MAX_DEF,
    localparam int AW = $clog2(PATH_MAX),
    localparam int UW = $clog2(NUM_ENTRIES + 1)
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  logic [UW-1:0]   used,
    input  logic [AW-1:0]   wr_addr,
    input  logic [7:0]      wr_data,
    input  logic            len_we,
    input  logic [AW-1:0]   len_val,
    input  logic            cmp_en,
    input  logic [AW-1:0]   cmp_addr,
    input  logic            cmp1,
    input  logic [7:0]      byte1,
    input  logic [AW-1:0]   flen,
    input  hrum_pkg::tok_t  tok_in,
    output hrum_pkg::tok_t  tok_out
);

    localparam int IW = hrum_pkg::INDEX_W;

    logic [7:0]     mem [PATH_MAX];
    logic [7:0]     rdata_reg;
    logic           elig_reg;
    logic [AW-1:0]  len_reg;
    logic           match_reg;
    hrum_pkg::tok_t tok_reg, tok_next;
    logic           sel;

    // The slot being filled is always the one at the current fill count.
    assign sel     = (used == UW'(SLOT));
    assign tok_out = tok_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en && sel)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmp_en)
        begin
            rdata_reg <= mem[cmp_addr];
            elig_reg  <= (used > UW'(SLOT)) && (len_reg > cmp_addr);
        end
    end

    always_comb
    begin
        tok_next = tok_in;
        if (tok_in.valid && !tok_in.done && match_reg && len_reg == flen)
        begin
            tok_next.done            = 1'b1;
            tok_next.res.status      = hrum_pkg::ST_OK;
            tok_next.res.entry_index = IW'(SLOT);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg   <= '0;
            match_reg <= 1'b1;
            tok_reg   <= '0;
        end
        else
        begin
            if (len_we && sel)
            begin
                len_reg <= len_val;
            end
            // The token passing by ends the request, so the flag rearms for the next one.
            if (tok_in.valid)
            begin
                match_reg <= 1'b1;
            end
            else if (cmp1 && !(elig_reg && rdata_reg == byte1))
            begin
                match_reg <= 1'b0;
            end
            tok_reg <= tok_next;
        end
    end

endmodule

// ----- hw/rtl/http_request_url_matcher_core.sv -----
// A registration result is formed as its last byte is accepted; a request result is set
// by the search token, which passes fin1_reg and fin2_reg and then walks the cell chain
// one slot per cycle. Other bytes are taken one per cycle unless the input stalls.
// The input stalls from a request's last byte until its result is formed, and for as
// long as a result waits in the skid register. Reset clears slot lengths, counts
// and parser state at once; path memory is not cleared.
module http_request_url_matcher_core #(
    parameter int NUM_ENTRIES = hrum_pkg::NUM_ENTRIES_DEF,
    parameter int PATH_MAX    = hrum_pkg::PATH_MAX_DEF,
    parameter int METHOD_MAX  = hrum_pkg::METHOD_MAX_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  hrum_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output hrum_pkg::result_t result
);

`include "http_request_url_matcher_core_assert.svh"

    localparam int AW = $clog2(PATH_MAX);
    localparam int UW = $clog2(NUM_ENTRIES + 1);

    logic              accept;
    logic              wr_en, len_we, cmp_en;
    logic [UW-1:0]     used;
    logic [AW-1:0]     wr_addr, len_val, cmp_addr, final_len;
    logic [7:0]        wr_data;
    hrum_pkg::evt_t    evt;

    logic              busy_reg;
    logic              cmp1_reg;
    logic [7:0]        byte1_reg;
    logic              fin1_reg, bad1_reg, fin2_reg, bad2_reg;
    logic [AW-1:0]     flen_reg;
    hrum_pkg::tok_t    tok [NUM_ENTRIES + 1];
    logic [NUM_ENTRIES-1:0] tok_v;
    hrum_pkg::tok_t    tail;

    logic              new_valid;
    hrum_pkg::result_t new_res;
    logic              out_free;
    logic              out_valid_reg, pend_valid_reg;
    hrum_pkg::result_t out_reg, pend_reg;

    assign item_stall   = busy_reg || pend_valid_reg;
    assign accept       = item_valid && !item_stall;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    hrum_front #(
        .NUM_ENTRIES (NUM_ENTRIES),
        .PATH_MAX    (PATH_MAX),
        .METHOD_MAX  (METHOD_MAX)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (item),
        .wr_en     (wr_en),
        .used      (used),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .len_we    (len_we),
        .len_val   (len_val),
        .cmp_en    (cmp_en),
        .cmp_addr  (cmp_addr),
        .final_len (final_len),
        .evt       (evt)
    );

    // A bad request enters the chain already resolved and passes through untouched.
    always_comb
    begin
        tok[0]                 = '0;
        tok[0].valid           = fin2_reg;
        tok[0].done            = bad2_reg;
        tok[0].res.status      = hrum_pkg::ST_BAD;
        tok[0].res.entry_index = '0;
    end

    for (genvar k = 0; k < NUM_ENTRIES; k++)
    begin : g_cell
        hrum_cell #(
            .SLOT        (k),
            .NUM_ENTRIES (NUM_ENTRIES),
            .PATH_MAX    (PATH_MAX)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .wr_en    (wr_en),
            .used     (used),
            .wr_addr  (wr_addr),
            .wr_data  (wr_data),
            .len_we   (len_we),
            .len_val  (len_val),
            .cmp_en   (cmp_en),
            .cmp_addr (cmp_addr),
            .cmp1     (cmp1_reg),
            .byte1    (byte1_reg),
            .flen     (flen_reg),
            .tok_in   (tok[k]),
            .tok_out  (tok[k+1])
        );
        assign tok_v[k] = tok[k+1].valid;
    end

    assign tail = tok[NUM_ENTRIES];

    always_comb
    begin
        new_valid = 1'b0;
        new_res   = evt.reg_res;
        if (evt.reg_valid)
        begin
            new_valid = 1'b1;
        end
        else if (tail.valid)
        begin
            new_valid = 1'b1;
            if (tail.done)
            begin
                new_res = tail.res;
            end
            else
            begin
                new_res.status      = hrum_pkg::ST_NOTFOUND;
                new_res.entry_index = '0;
            end
        end
    end

    assign out_free = !out_valid_reg || !result_stall;

    always_ff @(posedge clk)
    begin
        byte1_reg <= item.data_byte;
        if (accept && evt.fin)
        begin
            flen_reg <= final_len;
        end
        if (out_free)
        begin
            out_reg <= pend_valid_reg ? pend_reg : new_res;
        end
        if (new_valid && (!out_free || pend_valid_reg))
        begin
            pend_reg <= new_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            cmp1_reg       <= 1'b0;
            fin1_reg       <= 1'b0;
            bad1_reg       <= 1'b0;
            fin2_reg       <= 1'b0;
            bad2_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            cmp1_reg <= cmp_en;
            fin1_reg <= accept && evt.fin;
            bad1_reg <= evt.bad;
            fin2_reg <= fin1_reg;
            bad2_reg <= bad1_reg;
            if (accept && evt.fin)
            begin
                busy_reg <= 1'b1;
            end
            else if (tail.valid)
            begin
                busy_reg <= 1'b0;
            end
            if (out_free)
            begin
                out_valid_reg  <= pend_valid_reg || new_valid;
                pend_valid_reg <= pend_valid_reg && new_valid;
            end
            else if (new_valid)
            begin
                pend_valid_reg <= 1'b1;
            end
        end
    end

    `HRUM_ASSERT(a_one_token, $onehot0(tok_v), "more than one search token in the chain")
    `HRUM_ASSERT(a_token_busy, tail.valid |-> busy_reg, "search token finished while not busy")
    `HRUM_ASSERT(a_search_time, (accept && evt.fin) |-> ##(NUM_ENTRIES + 2) tail.valid,
                 "request search did not finish on time")
    `HRUM_NEVER(a_skid_overrun, pend_valid_reg && new_valid, "result arrived with skid full")

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for http_request_url_matcher_core: registers paths, streams requests
// and compares every result against a predictor of the matcher kept in this file.
// Depends on hrum_pkg and the core RTL only.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import hrum_pkg::*;

    localparam int SLOTS        = NUM_ENTRIES_DEF;
    localparam int PATH_LIMIT   = PATH_MAX_DEF;
    localparam int METHOD_LIMIT = METHOD_MAX_DEF;
    localparam int DIR_ROWS     = 22;
    localparam int RANDOM_ITEMS = 1950;
    localparam int PAUSE_SEQ    = 60;
    localparam int LONG_HOLD    = 300;
    // Covers a request search through the cell chain, plus a margin for the output skid.
    localparam int DRAIN_CYCLES = SLOTS + 3 + 20;

    typedef enum logic [1:0] {IN_METHOD, IN_PATH, PAST_PATH} parse_phase_t;

    typedef struct {
        item_t   it;
        bit      pause_first;
        bit      fixed;
        result_t want;
    } tx_t;

    typedef struct packed {
        logic                req_type;
        logic [7:0]          data_byte;
        logic                last_byte;
        logic                fixed;
        logic [STATUS_W-1:0] want_status;
        logic [INDEX_W-1:0]  want_index;
    } dir_row_t;

    // Rows with fixed set carry the result that follows directly from the stream so far.
    localparam dir_row_t DIRECTED_ROWS [DIR_ROWS] = '{
        '{TYPE_REQUEST,  "G",        1'b0, 1'b0, ST_OK,       4'd0},
        '{TYPE_REQUEST,  CHAR_SPACE, 1'b0, 1'b0, ST_OK,       4'd0},
        '{TYPE_REQUEST,  "/",        1'b1, 1'b1, ST_NOTFOUND, 4'd0},
        '{TYPE_REGISTER, CHAR_NUL,   1'b1, 1'b1, ST_REG,      4'd0},
        '{TYPE_REGISTER, "a",        1'b1, 1'b1, ST_REG,      4'd0},
        '{TYPE_REGISTER, 8'hFF,      1'b0, 1'b0, ST_OK,       4'd0},
        '{TYPE_REGISTER, CHAR_NUL,   1'b0, 1'b0, ST_OK,       4'd0},
        '{TYPE_REGISTER, "z",        1'b1, 1'b1, ST_REG,      4'd1},
        '{TYPE_REQUEST,  CHAR_SPACE, 1'b0, 1'b0, ST_OK,       4'd0},
        '{TYPE_REQUEST,  "a",        1'b1, 1'b1, ST_BAD,      4'd0},
        '{TYPE_REQUEST,  CHAR_NUL,   1'b1, 1'b1, ST_BAD,      4'd0},
        '{TYPE_REQUEST,  "X",        1'b0, 1'b0, ST_OK,       4'd0},
        '{TYPE_REQUEST,  CHAR_SPACE, 1'b0, 1'b0, ST_OK,       4'd0},
        '{TYPE_REQUEST,  "a",        1'b0, 1'b0, ST_OK,       4'd0},
        '{TYPE_REQUEST,  CHAR_CR,    1'b1, 1'b0, ST_OK,       4'd0},
        '{TYPE_REQUEST,  "X",        1'b0, 1'b0, ST_OK,       4'd0},
        '{TYPE_REQUEST,  CHAR_SPACE, 1'b0, 1'b0, ST_OK,       4'd0},
        '{TYPE_REQUEST,  8'hFF,      1'b1, 1'b0, ST_OK,       4'd0},
        '{TYPE_REQUEST,  "X",        1'b0, 1'b0, ST_OK,       4'd0},
        '{TYPE_REQUEST,  CHAR_SPACE, 1'b0, 1'b0, ST_OK,       4'd0},
        '{TYPE_REQUEST,  CHAR_SPACE, 1'b1, 1'b1, ST_BAD,      4'd0},
        '{TYPE_REQUEST,  "X",        1'b1, 1'b1, ST_BAD,      4'd0}
    };

    logic    clk = 1'b0;
    logic    rst_n;
    logic    item_valid;
    logic    item_stall;
    item_t   item;
    logic    result_valid;
    logic    result_stall;
    result_t result;

    http_request_url_matcher_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Predictor state: the path table and the progress of both byte streams.
    logic [7:0]       slot_bytes [SLOTS][PATH_LIMIT];
    int unsigned      slot_len [SLOTS];
    int unsigned      slots_used;
    int unsigned      reg_pos;
    bit               reg_closed;
    parse_phase_t     phase;
    int unsigned      parse_pos;
    logic [SLOTS-1:0] live_slots;
    bit               parse_err;

    // Generator shadow of the registered paths, used only to shape requests and registrations.
    logic [7:0] known_path [SLOTS][PATH_LIMIT];
    int         known_len [SLOTS];
    int         known_count;
    logic [7:0] draft [200];
    int         draft_len;
    item_t      reg_part[$];
    item_t      req_part[$];

    tx_t     tx_q[$];
    result_t outcome_q[$];
    int      errors;
    int      items_accepted;
    int      results_checked;
    int      seq_count;
    int      status_seen [8];

    function automatic void restart_parse();
        phase      = IN_METHOD;
        parse_pos  = 0;
        live_slots = '1;
        parse_err  = 1'b0;
    endfunction

    // Advances the matcher state by one transaction; returns 1 when it yields a result.
    function automatic bit compute_outcome(input item_t it, output result_t res);
        logic [7:0] b;
        b   = it.data_byte;
        res = '0;
        if (it.req_type == TYPE_REGISTER)
        begin
            if (!reg_closed)
            begin
                if (b == CHAR_NUL)
                    reg_closed = 1'b1;
                else if (slots_used < SLOTS && reg_pos < PATH_LIMIT - 1)
                begin
                    slot_bytes[slots_used][reg_pos] = b;
                    reg_pos++;
                end
            end
            if (!it.last_byte)
                return 1'b0;
            if (slots_used >= SLOTS)
                res.status = ST_FULL;
            else
            begin
                res.status      = ST_REG;
                res.entry_index = INDEX_W'(slots_used);
                // An empty registration reports the slot but leaves it empty.
                if (reg_pos > 0)
                begin
                    slot_len[slots_used] = reg_pos;
                    slots_used++;
                end
            end
            reg_pos    = 0;
            reg_closed = 1'b0;
            return 1'b1;
        end

        if (!parse_err && phase != PAST_PATH)
        begin
            if (phase == IN_METHOD)
            begin
                if (b == CHAR_SPACE)
                begin
                    if (parse_pos == 0)
                        parse_err = 1'b1;
                    phase     = IN_PATH;
                    parse_pos = 0;
                end
                else if (parse_pos >= METHOD_LIMIT - 1)
                    parse_err = 1'b1;
                else
                begin
                    if (parse_pos == 0 && b == CHAR_NUL)
                        parse_err = 1'b1;
                    parse_pos++;
                end
            end
            else if (b == CHAR_SPACE || b == CHAR_CR || b == CHAR_NUL ||
                     parse_pos >= PATH_LIMIT - 1)
                phase = PAST_PATH;
            else
            begin
                for (int k = 0; k < SLOTS; k++)
                    if (k >= slots_used || slot_len[k] <= parse_pos ||
                        slot_bytes[k][parse_pos] != b)
                        live_slots[k] = 1'b0;
                parse_pos++;
            end
        end
        if (!it.last_byte)
            return 1'b0;
        if (parse_err || phase == IN_METHOD || parse_pos == 0)
            res.status = ST_BAD;
        else
        begin
            res.status = ST_NOTFOUND;
            // Walk downward so the lowest matching slot is the one left standing.
            for (int k = SLOTS - 1; k >= 0; k--)
                if (k < slots_used && live_slots[k] && slot_len[k] == parse_pos)
                begin
                    res.status      = ST_OK;
                    res.entry_index = INDEX_W'(k);
                end
        end
        restart_parse();
        return 1'b1;
    endfunction

    function automatic item_t item_of(input logic kind, input logic [7:0] b);
        item_t x;
        x.req_type  = kind;
        x.data_byte = b;
        x.last_byte = 1'b0;
        return x;
    endfunction

    function automatic logic [7:0] path_char();
        logic [7:0] pick [4];
        pick = '{"a", "b", "/", "."};
        if ($urandom_range(0, 7) == 0)
            return 8'($urandom_range(1, 255));
        return pick[$urandom_range(0, 3)];
    endfunction

    function automatic logic [7:0] method_char();
        logic [7:0] c;
        if ($urandom_range(0, 3) != 0)
            return 8'($urandom_range(65, 90));
        c = 8'($urandom_range(0, 255));
        if (c == CHAR_SPACE)
            c = 8'hA0;
        return c;
    endfunction

    function automatic void fill_random(input int n);
        draft_len = n;
        for (int i = 0; i < n; i++)
            draft[i] = path_char();
    endfunction

    function automatic void draft_known(input int idx);
        draft_len = known_len[idx];
        for (int i = 0; i < draft_len; i++)
            draft[i] = known_path[idx][i];
    endfunction

    function automatic void build_registration();
        int kind;
        int eff;
        kind      = $urandom_range(0, 19);
        draft_len = 0;
        if (kind == 0)
            draft_len = 0;
        else if (kind <= 3 && known_count > 0)
        begin
            draft_known($urandom_range(0, known_count - 1));
            if (kind == 3)
            begin
                if (draft_len > 1 && $urandom_range(0, 1) == 1)
                    draft_len = $urandom_range(1, draft_len - 1);
                else
                    repeat ($urandom_range(1, 3))
                    begin
                        draft[draft_len] = path_char();
                        draft_len++;
                    end
            end
        end
        else if (kind == 4)
            fill_random($urandom_range(PATH_LIMIT - 2, PATH_LIMIT + 12));
        else
            fill_random($urandom_range(1, 6));

        for (int i = 0; i < draft_len; i++)
            reg_part.push_back(item_of(TYPE_REGISTER, draft[i]));
        // A zero byte ends the path; whatever follows it up to the last byte is dropped.
        if (draft_len == 0 || $urandom_range(0, 3) == 0)
        begin
            reg_part.push_back(item_of(TYPE_REGISTER, CHAR_NUL));
            repeat ($urandom_range(0, 2))
                reg_part.push_back(item_of(TYPE_REGISTER, 8'($urandom)));
        end
        reg_part[reg_part.size() - 1].last_byte = 1'b1;

        eff = (draft_len > PATH_LIMIT - 1) ? PATH_LIMIT - 1 : draft_len;
        if (eff > 0 && known_count < SLOTS)
        begin
            for (int i = 0; i < eff; i++)
                known_path[known_count][i] = draft[i];
            known_len[known_count] = eff;
            known_count++;
        end
    endfunction

    function automatic void build_request();
        int mk;
        int pk;
        int n;
        int idx;
        mk = $urandom_range(0, 15);
        if (mk == 0)
            n = 0;
        else if (mk == 1)
            n = $urandom_range(METHOD_LIMIT, METHOD_LIMIT + 2);
        else
            n = $urandom_range(1, METHOD_LIMIT - 1);
        for (int i = 0; i < n; i++)
            req_part.push_back(item_of(TYPE_REQUEST, method_char()));
        if (mk == 2)
            req_part[0].data_byte = CHAR_NUL;
        if (n > 0 && $urandom_range(0, 19) == 0)
        begin
            // The request ends before any space follows the method.
            req_part[req_part.size() - 1].last_byte = 1'b1;
            return;
        end
        req_part.push_back(item_of(TYPE_REQUEST, CHAR_SPACE));

        pk        = $urandom_range(0, 15);
        draft_len = 0;
        if (pk == 0)
            draft_len = 0;
        else if (pk <= 11 && known_count > 0)
        begin
            draft_known($urandom_range(0, known_count - 1));
            case (pk)
                9:
                    if (draft_len > 1)
                        draft_len = $urandom_range(1, draft_len - 1);
                10:
                    repeat ($urandom_range(1, 4))
                    begin
                        draft[draft_len] = path_char();
                        draft_len++;
                    end
                11:
                begin
                    idx        = $urandom_range(0, draft_len - 1);
                    draft[idx] = draft[idx] ^ 8'($urandom_range(1, 255));
                end
                default: ;
            endcase
        end
        else if (pk == 12)
            fill_random($urandom_range(PATH_LIMIT - 3, PATH_LIMIT + 7));
        else
            fill_random($urandom_range(1, 6));
        for (int i = 0; i < draft_len; i++)
            req_part.push_back(item_of(TYPE_REQUEST, draft[i]));

        case ($urandom_range(0, 5))
            1:
            begin
                req_part.push_back(item_of(TYPE_REQUEST, CHAR_SPACE));
                req_part.push_back(item_of(TYPE_REQUEST, "H"));
                req_part.push_back(item_of(TYPE_REQUEST, CHAR_CR));
                req_part.push_back(item_of(TYPE_REQUEST, 8'h0A));
            end
            2:
            begin
                req_part.push_back(item_of(TYPE_REQUEST, CHAR_CR));
                req_part.push_back(item_of(TYPE_REQUEST, 8'h0A));
            end
            3:
            begin
                req_part.push_back(item_of(TYPE_REQUEST, CHAR_NUL));
                repeat ($urandom_range(0, 2))
                    req_part.push_back(item_of(TYPE_REQUEST, 8'($urandom)));
            end
            4:
            begin
                req_part.push_back(item_of(TYPE_REQUEST, CHAR_SPACE));
                repeat ($urandom_range(0, 3))
                    req_part.push_back(item_of(TYPE_REQUEST, 8'($urandom)));
            end
            default: ;
        endcase
        req_part[req_part.size() - 1].last_byte = 1'b1;
    endfunction

    function automatic void build_noise();
        repeat ($urandom_range(1, 10))
            req_part.push_back(item_of(TYPE_REQUEST, 8'($urandom)));
        req_part[req_part.size() - 1].last_byte = 1'b1;
    endfunction

    task automatic check_outcome(input result_t got);
        result_t want;
        if (outcome_q.size() == 0)
        begin
            errors++;
            $display("%0t: result with nothing outstanding: status %0d entry_index %0d",
                     $time, got.status, got.entry_index);
            return;
        end
        want = outcome_q.pop_front();
        results_checked++;
        status_seen[want.status]++;
        if (got.status !== want.status)
        begin
            errors++;
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.status, got.status);
        end
        if (got.entry_index !== want.entry_index)
        begin
            errors++;
            $display("%0t: entry_index mismatch: expected %0d, actual %0d",
                     $time, want.entry_index, got.entry_index);
        end
    endtask

    // Sender: builds the whole stimulus, releases reset, then offers transactions in bursts.
    initial
    begin
        tx_t     tx;
        item_t   t;
        result_t res;
        bit      produced;
        bit      take_reg;
        bit      first;
        bit      offer;
        int      burst_left;
        int      gap_left;

        rst_n      <= 1'b0;
        item_valid <= 1'b0;
        item       <= '0;
        errors          = 0;
        items_accepted  = 0;
        results_checked = 0;
        seq_count       = 0;
        burst_left      = 0;
        gap_left        = 0;
        foreach (status_seen[s])
            status_seen[s] = 0;
        foreach (slot_len[s])
            slot_len[s] = 0;
        slots_used = 0;
        reg_pos    = 0;
        reg_closed = 1'b0;
        restart_parse();

        for (int r = 0; r < DIR_ROWS; r++)
        begin
            tx.it             = item_of(DIRECTED_ROWS[r].req_type, DIRECTED_ROWS[r].data_byte);
            tx.it.last_byte   = DIRECTED_ROWS[r].last_byte;
            tx.pause_first    = 1'b0;
            tx.fixed          = DIRECTED_ROWS[r].fixed;
            tx.want.status      = DIRECTED_ROWS[r].want_status;
            tx.want.entry_index = DIRECTED_ROWS[r].want_index;
            tx_q.push_back(tx);
        end
        // The directed rows leave "a" in slot 0 and the single byte FF in slot 1.
        known_path[0][0] = "a";
        known_len[0]     = 1;
        known_path[1][0] = 8'hFF;
        known_len[1]     = 1;
        known_count      = 2;

        while (tx_q.size() < DIR_ROWS + RANDOM_ITEMS)
        begin
            if (known_count < SLOTS)
                take_reg = ($urandom_range(0, 4) == 0) ||
                           (tx_q.size() > 1200 && $urandom_range(0, 1) == 1);
            else
                take_reg = ($urandom_range(0, 11) == 0);
            reg_part.delete();
            req_part.delete();
            if (!take_reg || $urandom_range(0, 5) == 0)
            begin
                if ($urandom_range(0, 9) == 0)
                    build_noise();
                else
                    build_request();
            end
            if (take_reg)
                build_registration();
            // When both streams are present their bytes are interleaved at random.
            first = 1'b1;
            while (reg_part.size() + req_part.size() > 0)
            begin
                if (req_part.size() == 0 || (reg_part.size() > 0 && $urandom_range(0, 1) == 1))
                    t = reg_part.pop_front();
                else
                    t = req_part.pop_front();
                tx_q.push_back('{it: t, pause_first: first && (seq_count == PAUSE_SEQ),
                                 fixed: 1'b0, want: '0});
                first = 1'b0;
            end
            seq_count++;
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (1)
        begin
            @(posedge clk);
            if (item_valid && !item_stall)
            begin
                tx = tx_q.pop_front();
                items_accepted++;
                if (burst_left > 0)
                    burst_left--;
                produced = compute_outcome(tx.it, res);
                if (tx.fixed)
                    res = tx.want;
                if (produced)
                    outcome_q.push_back(res);
            end
            if (tx_q.size() == 0)
            begin
                item_valid <= 1'b0;
                break;
            end
            offer = 1'b0;
            if (item_valid && item_stall)
                offer = 1'b1;
            else if (tx_q[0].pause_first && outcome_q.size() != 0)
                offer = 1'b0;
            else if (burst_left > 0)
                offer = 1'b1;
            else if (gap_left > 0)
                gap_left--;
            else
            begin
                burst_left = $urandom_range(1, 40);
                gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                offer      = 1'b1;
            end
            item_valid <= offer;
            if (offer)
                item <= tx_q[0].it;
        end

        while (outcome_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d input transactions in %0d sequences, %0d results checked.",
                 items_accepted, seq_count + 1, results_checked);
        $display("Results: %0d matched, %0d not found, %0d bad, %0d registered, %0d table full.",
                 status_seen[ST_OK], status_seen[ST_NOTFOUND], status_seen[ST_BAD],
                 status_seen[ST_REG], status_seen[ST_FULL]);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Receiver: checks each accepted result and stalls on its own changing pattern.
    initial
    begin
        int  hold_left;
        int  mode_left;
        int  stall_pct;
        bit  held_long;
        bit  next_stall;
        hold_left  = 0;
        mode_left  = 0;
        stall_pct  = 0;
        held_long  = 1'b0;
        result_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && !result_stall)
                check_outcome(result);
            // One long hold-off lets the block fill up and back-pressure its input.
            if (!held_long && results_checked >= 40)
            begin
                held_long = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                next_stall = 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode_left = $urandom_range(20, 200);
                    case ($urandom_range(0, 3))
                        0: stall_pct = 0;
                        1: stall_pct = 20;
                        2: stall_pct = 50;
                        default: stall_pct = 80;
                    endcase
                end
                mode_left--;
                next_stall = ($urandom_range(0, 99) < stall_pct);
            end
            result_stall <= next_stall;
        end
    end

    initial
    begin
        #2ms;
        $display("Timeout with %0d results outstanding", outcome_q.size());
        $display("Some tests failed");
        $finish;
    end

endmodule
